FILE: sv/ospd_pkg.sv
// ----------------------------------------------------------------------------
// Optical sweep pulse decoder package
// Shared widths, codes, reset values and the control word that travels from
// the classifier through the queue to the station tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ospd_pkg;

  // Default tick counter width and depth of the front-to-back queue.
  localparam int TIME_WIDTH_DEFAULT  = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration registers.
  localparam int LIMIT_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SWEEP_LIMIT = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SYNC_LIMIT  = 8'd1;
  localparam logic [LIMIT_WIDTH-1:0] SWEEP_LIMIT_RESET = 16'd500;
  localparam logic [LIMIT_WIDTH-1:0] SYNC_LIMIT_RESET  = 16'd990;

  // Width of the stored times as seen on the output ports.
  localparam int OUT_WIDTH = 32;

  // floor(w / 100) for w below 2^16 is (w * DIV100_MUL) >> DIV100_SHIFT.
  localparam int DIV100_MUL_WIDTH = 17;
  localparam logic [DIV100_MUL_WIDTH-1:0] DIV100_MUL = 17'd83887;
  localparam int DIV100_SHIFT = 23;
  localparam int DIV100_PROD_WIDTH = LIMIT_WIDTH + DIV100_MUL_WIDTH;

  // Class of a finished pulse.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SWEEP = 2'd1,
    KIND_SYNC  = 2'd2,
    KIND_SKIP  = 2'd3
  } kind_t;

  // Station codes for the index and the pending mark.
  typedef enum logic [1:0] {
    STATION_NONE = 2'd0,
    STATION_A    = 2'd1,
    STATION_B    = 2'd2,
    STATION_RSVD = 2'd3
  } station_t;

  // Slots of the stored times.
  localparam logic [1:0] SLOT_A_X = 2'd0;
  localparam logic [1:0] SLOT_B_X = 2'd2;
  localparam int NUM_SLOTS = 4;

  // Control word of one sample after classification.
  typedef struct packed {
    kind_t kind;
    logic  strobe;
    logic  width_even;
  } pulse_ctrl_t;

  localparam int CTRL_WIDTH = $bits(pulse_ctrl_t);

endpackage

`default_nettype wire

FILE: sv/ospd_front.sv
// ----------------------------------------------------------------------------
// Optical sweep pulse decoder front end
// Holds the threshold registers, detects edges, measures each high pulse and
// classifies it into a control word for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ospd_front #(
  parameter int TIME_WIDTH = ospd_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   optical_level,
  input  wire  [TIME_WIDTH-1:0]                 tick_time,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [ospd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire  [ospd_pkg::LIMIT_WIDTH-1:0]      cfg_data,
  output logic                                  q_valid,
  input  wire                                   q_ready,
  output ospd_pkg::pulse_ctrl_t                 q_ctrl,
  output logic [TIME_WIDTH-1:0]                 q_pulse_start
);
  import ospd_pkg::*;

  logic [LIMIT_WIDTH-1:0] sweep_limit;
  logic [LIMIT_WIDTH-1:0] sync_limit;

  logic                  prev_level;
  logic                  in_pulse;
  logic [TIME_WIDTH-1:0] pulse_start;

  logic                  s1_valid;
  logic                  s1_strobe;
  logic                  s1_ended;
  logic [TIME_WIDTH-1:0] s1_width;
  logic [TIME_WIDTH-1:0] s1_pulse_start;

  logic                         accept;
  logic                         level_rise;
  logic                         level_fall;
  kind_t                        kind;
  logic [DIV100_PROD_WIDTH-1:0] div_prod;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_limit <= SWEEP_LIMIT_RESET;
      sync_limit  <= SYNC_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SWEEP_LIMIT) begin
        sweep_limit <= cfg_data;
      end else if (cfg_index == REG_SYNC_LIMIT) begin
        sync_limit <= cfg_data;
      end
    end
  end

  // The measuring stage moves whenever it is empty or the queue takes it.
  assign in_ready   = !s1_valid || q_ready;
  assign accept     = in_valid && in_ready;
  assign level_rise = !prev_level && optical_level;
  assign level_fall = prev_level && !optical_level;

  // Edge detection and pulse width measurement.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level  <= 1'b0;
      in_pulse    <= 1'b0;
      pulse_start <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (accept) begin
        prev_level <= optical_level;
        if (level_rise && !in_pulse) begin
          pulse_start <= tick_time;
          in_pulse    <= 1'b1;
        end else if (level_fall && in_pulse) begin
          in_pulse <= 1'b0;
        end
      end
    end
  end

  // Payload of the measuring stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_strobe      <= level_rise || level_fall;
      s1_ended       <= level_fall && in_pulse;
      s1_width       <= tick_time - pulse_start;
      s1_pulse_start <= pulse_start;
    end
  end

  // Classification against the thresholds.
  always_comb begin
    if (!s1_ended) begin
      kind = KIND_NONE;
    end else if (s1_width < TIME_WIDTH'(sweep_limit)) begin
      kind = KIND_SWEEP;
    end else if (s1_width < TIME_WIDTH'(sync_limit)) begin
      kind = KIND_SYNC;
    end else begin
      kind = KIND_SKIP;
    end
  end

  // Parity of width / 100; only needed for syncs, whose width is below 2^16.
  assign div_prod = DIV100_PROD_WIDTH'(s1_width[LIMIT_WIDTH-1:0]) *
                    DIV100_PROD_WIDTH'(DIV100_MUL);

  assign q_valid            = s1_valid;
  assign q_ctrl.kind        = kind;
  assign q_ctrl.strobe      = s1_strobe;
  assign q_ctrl.width_even  = !div_prod[DIV100_SHIFT];
  assign q_pulse_start      = s1_pulse_start;

endmodule

`default_nettype wire

FILE: sv/ospd_queue.sv
// ----------------------------------------------------------------------------
// Optical sweep pulse decoder queue
// Small register queue that decouples the classifier from the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module ospd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ospd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire  [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]       entries [DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr;
  logic [PTR_WIDTH-1:0]   rd_ptr;
  logic [COUNT_WIDTH-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != COUNT_WIDTH'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ospd_back.sv
// ----------------------------------------------------------------------------
// Optical sweep pulse decoder back end
// Tracks sync windows, axis and station, stores sync-to-sweep times and holds
// the output word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ospd_back #(
  parameter int TIME_WIDTH = ospd_pkg::TIME_WIDTH_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               q_valid,
  output logic                              q_ready,
  input  ospd_pkg::pulse_ctrl_t             q_ctrl,
  input  wire  [TIME_WIDTH-1:0]             q_pulse_start,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [ospd_pkg::OUT_WIDTH-1:0]    a_x,
  output logic [ospd_pkg::OUT_WIDTH-1:0]    a_y,
  output logic [ospd_pkg::OUT_WIDTH-1:0]    b_x,
  output logic [ospd_pkg::OUT_WIDTH-1:0]    b_y,
  output logic [1:0]                        pulse_kind,
  output logic                              edge_strobe
);
  import ospd_pkg::*;

  logic [TIME_WIDTH-1:0] window_start;
  station_t              station_index;
  station_t              pending_station;
  logic                  axis_is_x;
  logic [TIME_WIDTH-1:0] times [NUM_SLOTS];
  kind_t                 out_kind;
  logic                  out_strobe;

  logic                  pop;
  logic [TIME_WIDTH-1:0] sweep_dt;
  logic [1:0]            slot;

  // The stored times are the output payload, so a word is popped only
  // when the output register is free.
  assign q_ready  = !out_valid || out_ready;
  assign pop      = q_valid && q_ready;
  assign sweep_dt = q_pulse_start - window_start;
  assign slot     = ((pending_station == STATION_B) ? SLOT_B_X : SLOT_A_X) +
                    {1'b0, !axis_is_x};

  // Station tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start    <= '0;
      station_index   <= STATION_NONE;
      pending_station <= STATION_NONE;
      axis_is_x       <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        times[i] <= '0;
      end
    end else if (pop) begin
      unique case (q_ctrl.kind)
        KIND_SYNC: begin
          window_start <= q_pulse_start;
          if (station_index != STATION_NONE) begin
            axis_is_x       <= q_ctrl.width_even;
            pending_station <= station_index;
          end
        end
        KIND_SWEEP: begin
          station_index <= STATION_A;
          if (pending_station == STATION_A || pending_station == STATION_B) begin
            times[slot]     <= sweep_dt;
            pending_station <= STATION_NONE;
          end
        end
        KIND_SKIP: begin
          if (station_index == STATION_A) begin
            station_index <= STATION_B;
          end
        end
        KIND_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind   <= q_ctrl.kind;
      out_strobe <= q_ctrl.strobe;
    end
  end

  // Stored times are shown in their low bits, zero extended when narrower.
  logic [TIME_WIDTH+OUT_WIDTH-1:0] ext_a_x;
  logic [TIME_WIDTH+OUT_WIDTH-1:0] ext_a_y;
  logic [TIME_WIDTH+OUT_WIDTH-1:0] ext_b_x;
  logic [TIME_WIDTH+OUT_WIDTH-1:0] ext_b_y;

  assign ext_a_x = {{OUT_WIDTH{1'b0}}, times[0]};
  assign ext_a_y = {{OUT_WIDTH{1'b0}}, times[1]};
  assign ext_b_x = {{OUT_WIDTH{1'b0}}, times[2]};
  assign ext_b_y = {{OUT_WIDTH{1'b0}}, times[3]};

  assign a_x         = ext_a_x[OUT_WIDTH-1:0];
  assign a_y         = ext_a_y[OUT_WIDTH-1:0];
  assign b_x         = ext_b_x[OUT_WIDTH-1:0];
  assign b_y         = ext_b_y[OUT_WIDTH-1:0];
  assign pulse_kind  = out_kind;
  assign edge_strobe = out_strobe;

endmodule

`default_nettype wire

FILE: sv/optical_sweep_pulse_decoder.sv
// ----------------------------------------------------------------------------
// Optical sweep pulse decoder
// Path: a sample is loaded into the measure stage register when accepted, then
// into a queue entry and then into the tracker output register, which drives
// the result word; back-pressure can hold it at each step.
// Throughput: one sample per cycle while out_ready stays high.
// Reset: synchronous; thresholds return to 500 and 990, valid flags, pointers and tracker state clear.
// ----------------------------------------------------------------------------
`default_nettype none

module optical_sweep_pulse_decoder #(
  parameter int TIME_WIDTH  = ospd_pkg::TIME_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = ospd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   optical_level,
  input  wire  [TIME_WIDTH-1:0]                 tick_time,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [ospd_pkg::OUT_WIDTH-1:0]        a_x,
  output logic [ospd_pkg::OUT_WIDTH-1:0]        a_y,
  output logic [ospd_pkg::OUT_WIDTH-1:0]        b_x,
  output logic [ospd_pkg::OUT_WIDTH-1:0]        b_y,
  output logic [1:0]                            pulse_kind,
  output logic                                  edge_strobe,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [ospd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire  [ospd_pkg::LIMIT_WIDTH-1:0]      cfg_data
);
  import ospd_pkg::*;

  localparam int ENTRY_WIDTH = CTRL_WIDTH + TIME_WIDTH;

  logic                  f_valid;
  logic                  f_ready;
  pulse_ctrl_t           f_ctrl;
  logic [TIME_WIDTH-1:0] f_pulse_start;

  logic                  b_valid;
  logic                  b_ready;
  logic [ENTRY_WIDTH-1:0] b_entry;
  pulse_ctrl_t           b_ctrl;
  logic [TIME_WIDTH-1:0] b_pulse_start;

  // Edge detection, measurement and classification.
  ospd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .optical_level (optical_level),
    .tick_time     (tick_time),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_ctrl        (f_ctrl),
    .q_pulse_start (f_pulse_start)
  );

  // Queue between the classifier and the tracker.
  ospd_queue #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctrl, f_pulse_start}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_entry)
  );

  assign b_ctrl        = pulse_ctrl_t'(b_entry[ENTRY_WIDTH-1:TIME_WIDTH]);
  assign b_pulse_start = b_entry[TIME_WIDTH-1:0];

  // Station tracking and output word.
  ospd_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_ctrl        (b_ctrl),
    .q_pulse_start (b_pulse_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .a_x           (a_x),
    .a_y           (a_y),
    .b_x           (b_x),
    .b_y           (b_y),
    .pulse_kind    (pulse_kind),
    .edge_strobe   (edge_strobe)
  );

endmodule

`default_nettype wire
